// ===== src/rsz_pkg.sv =====
// Shared types, constants and helpers for the bilinear resizer.
// Used by every module of the block but rsz_ram; depends on nothing.
package rsz_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;

   localparam int XW          = $clog2(MAX_WIDTH);
   localparam int YW          = $clog2(MAX_HEIGHT);
   localparam int AXIS_W      = (XW > YW) ? XW : YW;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = FRAC_W + AXIS_W;
   localparam int CSR_W       = 9;
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 8;
   localparam int WF_W        = 8;
   localparam int WT_W        = WF_W + 1;
   localparam int WT_ONE      = 256;

   localparam int BANK_AW     = (XW - 1) + (YW - 1);
   localparam int BANK_DEPTH  = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
   localparam int BANKS       = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_CNT_W   = $clog2(STEP_W);

   // size registers after reset, already clamped to the store
   localparam int RST_SRC_W   = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
   localparam int RST_SRC_H   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int RST_DST_W   = (MAX_WIDTH  < 32)  ? MAX_WIDTH  : 32;
   localparam int RST_DST_H   = (MAX_HEIGHT < 32)  ? MAX_HEIGHT : 32;
   localparam int RST_COL_STEP = (RST_DST_W <= 1) ? 0 :
                                 ((RST_SRC_W - 1) << FRAC_W) / (RST_DST_W - 1);
   localparam int RST_ROW_STEP = (RST_DST_H <= 1) ? 0 :
                                 ((RST_SRC_H - 1) << FRAC_W) / (RST_DST_H - 1);

   typedef enum logic {
      REQ_LOAD    = 1'b0,
      REQ_COMPUTE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_addr_type;

   typedef enum logic {
      DIV_IDLE = 1'b0,
      DIV_RUN  = 1'b1
   } div_state_type;

   typedef struct packed {
      req_kind_type         req_type;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIX_W-1:0]     pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0]     pixel_out;
      logic                 bad_request;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_W-1:0]     src_width;
      logic [CSR_W-1:0]     src_height;
   } size_type;

   // one queued request, already classified by the front end
   typedef struct packed {
      req_kind_type         kind;
      logic                 bad;
      logic                 store_ok;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIX_W-1:0]     pixel;
      logic [STEP_W-1:0]    pos_x;
      logic [STEP_W-1:0]    pos_y;
   } q_entry_type;

   // zero reads as one, anything above the store size as the store size
   function automatic logic [CSR_W-1:0] clamp_size(input logic [CSR_W-1:0] v,
                                                   input int maxv);
      logic [CSR_W-1:0] r;
      if (v == '0) begin
         r = CSR_W'(1);
      end else if (int'(v) > maxv) begin
         r = CSR_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== src/rsz_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module rsz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rsz_div.sv =====
// Shift-subtract divider for the 8.16 resize step, one quotient bit a cycle.
// Depends on rsz_pkg.
module rsz_div
   import rsz_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [STEP_W-1:0] num,
   input  logic [AXIS_W-1:0] den,
   output logic              busy,
   output logic              done,
   output logic [STEP_W-1:0] quo
);

   div_state_type         state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AXIS_W-1:0]     rem_ff, rem_in;
   logic [AXIS_W-1:0]     den_ff, den_in;
   logic [STEP_W-1:0]     quo_ff, quo_in;
   logic                  zero_ff, zero_in;
   logic                  done_ff, done_in;
   logic [AXIS_W:0]       trial;
   logic                  fits;
   logic                  last;

   assign last  = (cnt_ff == DIV_CNT_W'(STEP_W - 1));
   assign trial = {rem_ff, quo_ff[STEP_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (start) begin
            state_in = DIV_RUN;
         end
         DIV_RUN: if (!start && last) begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = (state_ff == DIV_RUN);
      done = done_ff;
      quo  = zero_ff ? '0 : quo_ff;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      done_in = (state_ff == DIV_RUN) && last && !start;
      // a new start also restarts a division in progress
      if (start) begin
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
         // destination size of one: step is zero
         zero_in = (den == '0);
      end else if (state_ff == DIV_RUN) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = fits ? AXIS_W'(trial - {1'b0, den_ff}) : trial[AXIS_W-1:0];
         quo_in = {quo_ff[STEP_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         zero_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== src/rsz_front.sv =====
// Front end: size registers, step dividers, request intake and classification,
// source position multiply, and the request queue. Depends on rsz_pkg, rsz_div.
module rsz_front
   import rsz_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic            csr_we,
   input  csr_addr_type    csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   output logic            q_valid,
   output q_entry_type     q_entry,
   input  logic            q_pop,
   output size_type        sizes
);

   logic [CSR_W-1:0]   src_w_ff, src_w_in;
   logic [CSR_W-1:0]   src_h_ff, src_h_in;
   logic [CSR_W-1:0]   dst_w_ff, dst_w_in;
   logic [CSR_W-1:0]   dst_h_ff, dst_h_in;
   logic               start_ff, start_in;
   logic [STEP_W-1:0]  col_step_ff, col_step_in;
   logic [STEP_W-1:0]  row_step_ff, row_step_in;

   logic [STEP_W-1:0]  col_num, row_num, col_quo, row_quo;
   logic [AXIS_W-1:0]  col_den, row_den;
   logic               col_busy, row_busy, col_done, row_done;
   logic               cfg_hold;

   q_entry_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push;
   q_entry_type        push_entry;
   logic [COORD_W+STEP_W-1:0] col_prod, row_prod;

   // size registers and step re-derivation
   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_WIDTH:  src_w_in = clamp_size(csr_wdata, MAX_WIDTH);
            CSR_SRC_HEIGHT: src_h_in = clamp_size(csr_wdata, MAX_HEIGHT);
            CSR_DST_WIDTH:  dst_w_in = clamp_size(csr_wdata, MAX_WIDTH);
            CSR_DST_HEIGHT: dst_h_in = clamp_size(csr_wdata, MAX_HEIGHT);
         endcase
      end
      start_in    = csr_we;
      col_step_in = col_done ? col_quo : col_step_ff;
      row_step_in = row_done ? row_quo : row_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= CSR_W'(RST_SRC_W);
         src_h_ff    <= CSR_W'(RST_SRC_H);
         dst_w_ff    <= CSR_W'(RST_DST_W);
         dst_h_ff    <= CSR_W'(RST_DST_H);
         start_ff    <= 1'b0;
         col_step_ff <= STEP_W'(RST_COL_STEP);
         row_step_ff <= STEP_W'(RST_ROW_STEP);
      end else begin
         src_w_ff    <= src_w_in;
         src_h_ff    <= src_h_in;
         dst_w_ff    <= dst_w_in;
         dst_h_ff    <= dst_h_in;
         start_ff    <= start_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
      end
   end

   // (src - 1) << 16 over (dst - 1)
   assign col_num = {AXIS_W'(src_w_ff - CSR_W'(1)), {FRAC_W{1'b0}}};
   assign row_num = {AXIS_W'(src_h_ff - CSR_W'(1)), {FRAC_W{1'b0}}};
   assign col_den = AXIS_W'(dst_w_ff - CSR_W'(1));
   assign row_den = AXIS_W'(dst_h_ff - CSR_W'(1));

   rsz_div u_col_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (col_num),
      .den   (col_den),
      .busy  (col_busy),
      .done  (col_done),
      .quo   (col_quo)
   );

   rsz_div u_row_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (row_num),
      .den   (row_den),
      .busy  (row_busy),
      .done  (row_done),
      .quo   (row_quo)
   );

   // no intake from a size write until both new steps are in place
   assign cfg_hold  = csr_we || start_ff || col_busy || row_busy || col_done || row_done;
   assign req_ready = !cfg_hold && (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   assign col_prod = {{STEP_W{1'b0}}, req_data.col} * {{COORD_W{1'b0}}, col_step_ff};
   assign row_prod = {{STEP_W{1'b0}}, req_data.row} * {{COORD_W{1'b0}}, row_step_ff};

   always_comb begin
      push_entry.kind     = req_data.req_type;
      push_entry.bad      = (CSR_W'(req_data.col) >= dst_w_ff) ||
                            (CSR_W'(req_data.row) >= dst_h_ff);
      push_entry.store_ok = (int'(req_data.col) < MAX_WIDTH) &&
                            (int'(req_data.row) < MAX_HEIGHT);
      push_entry.col      = req_data.col;
      push_entry.row      = req_data.row;
      push_entry.pixel    = req_data.pixel_in;
      push_entry.pos_x    = col_prod[STEP_W-1:0];
      push_entry.pos_y    = row_prod[STEP_W-1:0];
   end

   // request queue
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_valid          = (cnt_ff != '0);
   assign q_entry          = q_ff[rd_ptr_ff];
   assign sizes.src_width  = src_w_ff;
   assign sizes.src_height = src_h_ff;

endmodule

// ===== src/rsz_back.sv =====
// Back end: parity-banked frame store, neighbor fetch with edge clamp,
// two-stage blend and the result register. Depends on rsz_pkg, rsz_ram.
module rsz_back
   import rsz_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  q_entry_type     q_entry,
   output logic            q_pop,
   input  size_type        sizes,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int BL_W  = PIX_W + WT_W;
   localparam int SUM_W = BL_W + WT_W;

   logic               advance;
   logic               rd_issue;
   logic [XW-1:0]      x, xn, col_idx;
   logic [YW-1:0]      y, yn, row_idx;
   logic               x_edge, y_edge;
   logic [PIX_W-1:0]   bank_rdata [BANKS];

   logic               s2_valid_ff, s2_valid_in;
   logic               s2_bad_ff, s2_bad_in;
   logic [WF_W-1:0]    s2_xf_ff, s2_xf_in;
   logic [WF_W-1:0]    s2_yf_ff, s2_yf_in;
   logic               s2_xedge_ff, s2_xedge_in;
   logic               s2_yedge_ff, s2_yedge_in;
   logic               s2_x0_ff, s2_x0_in;
   logic               s2_y0_ff, s2_y0_in;

   logic [1:0]         b00, b10, b01, b11;
   logic [PIX_W-1:0]   p00, p10, p01, p11;
   logic [WT_W-1:0]    xi, yi;

   logic               s3_valid_ff, s3_valid_in;
   logic               s3_bad_ff, s3_bad_in;
   logic [BL_W-1:0]    s3_top_ff, s3_top_in;
   logic [BL_W-1:0]    s3_bot_ff, s3_bot_in;
   logic [WF_W-1:0]    s3_yf_ff, s3_yf_in;

   logic [SUM_W-1:0]   sum;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   // whole back pipeline moves together when the result register can take one
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign q_pop    = advance && q_valid;
   assign rd_issue = q_pop && (q_entry.kind == REQ_COMPUTE);

   assign x       = q_entry.pos_x[FRAC_W +: XW];
   assign y       = q_entry.pos_y[FRAC_W +: YW];
   assign xn      = x + 1'b1;
   assign yn      = y + 1'b1;
   assign x_edge  = (CSR_W'(x) + CSR_W'(1)) >= sizes.src_width;
   assign y_edge  = (CSR_W'(y) + CSR_W'(1)) >= sizes.src_height;
   assign col_idx = XW'(q_entry.col);
   assign row_idx = YW'(q_entry.row);

   // bank index is {row parity, column parity}; each bank serves whichever
   // of x / x+1 and y / y+1 has its parity
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      localparam logic CP = 1'(b % 2);
      localparam logic RP = 1'(b / 2);
      logic [XW-1:0]      col_sel;
      logic [YW-1:0]      row_sel;
      logic [BANK_AW-1:0] rd_addr;
      logic [BANK_AW-1:0] wr_addr;
      logic               wr_en;

      assign col_sel = (x[0] == CP) ? x : xn;
      assign row_sel = (y[0] == RP) ? y : yn;
      assign rd_addr = {row_sel[YW-1:1], col_sel[XW-1:1]};
      assign wr_addr = {row_idx[YW-1:1], col_idx[XW-1:1]};
      assign wr_en   = q_pop && (q_entry.kind == REQ_LOAD) && q_entry.store_ok &&
                       (row_idx[0] == RP) && (col_idx[0] == CP);

      rsz_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (q_entry.pixel),
         .rd_en   (rd_issue),
         .rd_addr (rd_addr),
         .rd_data (bank_rdata[b])
      );
   end

   // stage 2: neighbor select and horizontal blend
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_bad_in   = s2_bad_ff;
      s2_xf_in    = s2_xf_ff;
      s2_yf_in    = s2_yf_ff;
      s2_xedge_in = s2_xedge_ff;
      s2_yedge_in = s2_yedge_ff;
      s2_x0_in    = s2_x0_ff;
      s2_y0_in    = s2_y0_ff;
      if (advance) begin
         s2_valid_in = rd_issue;
         s2_bad_in   = q_entry.bad;
         s2_xf_in    = q_entry.pos_x[FRAC_W-WF_W +: WF_W];
         s2_yf_in    = q_entry.pos_y[FRAC_W-WF_W +: WF_W];
         s2_xedge_in = x_edge;
         s2_yedge_in = y_edge;
         s2_x0_in    = x[0];
         s2_y0_in    = y[0];
      end
   end

   always_comb begin
      // at a clamped edge the far neighbor is the near one
      b00 = {s2_y0_ff, s2_x0_ff};
      b10 = {s2_y0_ff, s2_x0_ff ^ !s2_xedge_ff};
      b01 = {s2_y0_ff ^ !s2_yedge_ff, s2_x0_ff};
      b11 = {s2_y0_ff ^ !s2_yedge_ff, s2_x0_ff ^ !s2_xedge_ff};
      p00 = bank_rdata[b00];
      p10 = bank_rdata[b10];
      p01 = bank_rdata[b01];
      p11 = bank_rdata[b11];
      xi  = WT_W'(WT_ONE) - {1'b0, s2_xf_ff};

      s3_valid_in = s3_valid_ff;
      s3_bad_in   = s3_bad_ff;
      s3_top_in   = s3_top_ff;
      s3_bot_in   = s3_bot_ff;
      s3_yf_in    = s3_yf_ff;
      if (advance) begin
         s3_valid_in = s2_valid_ff;
         s3_bad_in   = s2_bad_ff;
         s3_top_in   = {{WT_W{1'b0}}, p00} * {{PIX_W{1'b0}}, xi} +
                       {{WT_W{1'b0}}, p10} * {{PIX_W+1{1'b0}}, s2_xf_ff};
         s3_bot_in   = {{WT_W{1'b0}}, p01} * {{PIX_W{1'b0}}, xi} +
                       {{WT_W{1'b0}}, p11} * {{PIX_W+1{1'b0}}, s2_xf_ff};
         s3_yf_in    = s2_yf_ff;
      end
   end

   // stage 3: vertical blend into the result register
   always_comb begin
      yi  = WT_W'(WT_ONE) - {1'b0, s3_yf_ff};
      sum = {{WT_W{1'b0}}, s3_top_ff} * {{BL_W{1'b0}}, yi} +
            {{WT_W{1'b0}}, s3_bot_ff} * {{BL_W+1{1'b0}}, s3_yf_ff};

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in            = s3_valid_ff;
         rsp_data_in.bad_request = s3_bad_ff;
         rsp_data_in.pixel_out   = s3_bad_ff ? '0 : sum[2*WF_W +: PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_bad_ff   <= s2_bad_in;
      s2_xf_ff    <= s2_xf_in;
      s2_yf_ff    <= s2_yf_in;
      s2_xedge_ff <= s2_xedge_in;
      s2_yedge_ff <= s2_yedge_in;
      s2_x0_ff    <= s2_x0_in;
      s2_y0_ff    <= s2_y0_in;
      s3_bad_ff   <= s3_bad_in;
      s3_top_ff   <= s3_top_in;
      s3_bot_ff   <= s3_bot_in;
      s3_yf_ff    <= s3_yf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/bilinear_image_resize.sv =====
// Top level of the grayscale bilinear resizer: front end and back end.
// Depends on rsz_pkg, rsz_front, rsz_back.
//
//   channel  ports                           direction  handshake
//   request  req_valid req_ready req_data    in         valid/ready, req_payload_type
//   result   rsp_valid rsp_ready rsp_data    out        valid/ready, rsp_payload_type
//   config   csr_we csr_addr csr_wdata       in         write strobe, no read-back
//
// One request per cycle while req_ready is high; a compute result is registered in the
// queue, stages 2 and 3 and the result register, and is taken at the next edge when
// rsp_ready is high; a load gives no result. A size write re-derives both steps in a
// 24-step shift-subtract divider; req_ready is low until both new steps are in place.
// Reset is synchronous; the frame store is not cleared and gets no reset pass.
// rsp_ready low freezes the back pipeline only; a four-entry queue keeps taking
// requests until it fills.
module bilinear_image_resize
   import rsz_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_data,
   input  logic             csr_we,
   input  csr_addr_type     csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic        q_valid;
   q_entry_type q_entry;
   logic        q_pop;
   size_type    sizes;

   rsz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .sizes     (sizes)
   );

   rsz_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .sizes     (sizes),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/tb_bilinear_image_resize.sv =====
// Testbench for bilinear_image_resize: directed and random load/compute traffic
// under random idling on both channels, checked against a bilinear predictor.
// Depends on rsz_pkg and the block under src/.
module tb_bilinear_image_resize;
   import rsz_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 12;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_data;
   logic             csr_we    = 1'b0;
   csr_addr_type     csr_addr  = CSR_SRC_WIDTH;
   logic [CSR_W-1:0] csr_wdata = '0;

   int   send_gap_pct   = 0;
   int   recv_stall_pct = 0;
   logic settle         = 1'b0;
   int   errors         = 0;
   int   cycles         = 0;

   // predictor state: source image, which entries hold data, sizes and steps
   logic [PIX_W-1:0]  src_img [MAX_HEIGHT][MAX_WIDTH];
   bit                loaded  [MAX_HEIGHT][MAX_WIDTH];
   int unsigned       src_w, src_h, dst_w, dst_h;
   logic [STEP_W-1:0] col_step, row_step;
   rsp_payload_type   pending_pixels[$];
   rsp_payload_type   oldest_pixel;

   bilinear_image_resize dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, compare every transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected result: pixel_out=%0d bad_request=%0b",
                      rsp_data.pixel_out, rsp_data.bad_request);
               errors++;
            end else begin
               oldest_pixel = pending_pixels.pop_front();
               if (rsp_data.pixel_out !== oldest_pixel.pixel_out) begin
                  $error("pixel_out: expected %0d, got %0d",
                         oldest_pixel.pixel_out, rsp_data.pixel_out);
                  errors++;
               end
               if (rsp_data.bad_request !== oldest_pixel.bad_request) begin
                  $error("bad_request: expected %0b, got %0b",
                         oldest_pixel.bad_request, rsp_data.bad_request);
                  errors++;
               end
            end
         end
         rsp_ready <= settle || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic int unsigned clip_size(logic [CSR_W-1:0] value, int unsigned top);
      if (value == '0) return 1;
      if (value > top) return top;
      return 32'(value);
   endfunction

   function automatic logic [STEP_W-1:0] step_for(int unsigned s, int unsigned d);
      longint unsigned num;
      if (d <= 1) return '0;
      num = 64'(s - 1);
      return STEP_W'((num << FRAC_W) / 64'(d - 1));
   endfunction

   function automatic void retune_steps();
      col_step = step_for(src_w, dst_w);
      row_step = step_for(src_h, dst_h);
   endfunction

   // top-left neighbour, clamped right/bottom neighbour and 8-bit fractions
   function automatic void locate(input int unsigned c, input int unsigned r,
                                  output int unsigned x0, output int unsigned y0,
                                  output int unsigned x1, output int unsigned y1,
                                  output int unsigned fx, output int unsigned fy);
      longint unsigned px, py;
      px = 64'(c);
      py = 64'(r);
      px = px * 64'(col_step);
      py = py * 64'(row_step);
      x0 = 32'(px >> FRAC_W);
      y0 = 32'(py >> FRAC_W);
      fx = 32'((px >> 8) & 64'hFF);
      fy = 32'((py >> 8) & 64'hFF);
      x1 = (x0 + 1 < src_w) ? x0 + 1 : x0;
      y1 = (y0 + 1 < src_h) ? y0 + 1 : y0;
   endfunction

   function automatic rsp_payload_type interp_pixel(int unsigned c, int unsigned r);
      rsp_payload_type res;
      int unsigned x0, y0, x1, y1, fx, fy, acc;
      res = '0;
      if (c >= dst_w || r >= dst_h) begin
         res.bad_request = 1'b1;
      end else begin
         locate(c, r, x0, y0, x1, y1, fx, fy);
         acc = 32'(src_img[y0][x0]) * (WT_ONE - fx) * (WT_ONE - fy)
             + 32'(src_img[y0][x1]) * fx * (WT_ONE - fy)
             + 32'(src_img[y1][x0]) * (WT_ONE - fx) * fy
             + 32'(src_img[y1][x1]) * fx * fy;
         res.pixel_out = PIX_W'(acc >> FRAC_W);
      end
      return res;
   endfunction

   function automatic void absorb(req_payload_type item);
      if (item.req_type == REQ_LOAD) begin
         src_img[item.row][item.col] = item.pixel_in;
         loaded[item.row][item.col]  = 1'b1;
      end else begin
         pending_pixels.push_back(interp_pixel(32'(item.col), 32'(item.row)));
      end
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] rand_size();
      case ($urandom_range(7))
         0: return '0;
         1: return CSR_W'($urandom_range(511, 257));
         2: return CSR_W'(256);
         3, 4: return CSR_W'($urandom_range(8, 1));
         default: return CSR_W'($urandom_range(256, 1));
      endcase
   endfunction

   // valid stays high between back-to-back transfers; it drops for a gap and in hold_until_empty
   task automatic send_req(req_payload_type item);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      absorb(item);
   endtask

   task automatic load_px(int unsigned c, int unsigned r, logic [PIX_W-1:0] value);
      req_payload_type item;
      item.req_type = REQ_LOAD;
      item.col      = COORD_W'(c);
      item.row      = COORD_W'(r);
      item.pixel_in = value;
      send_req(item);
   endtask

   // loads any neighbour not yet written, then sends the compute request
   task automatic resize_at(int unsigned c, int unsigned r);
      int unsigned x0, y0, x1, y1, fx, fy;
      req_payload_type item;
      if (c < dst_w && r < dst_h) begin
         locate(c, r, x0, y0, x1, y1, fx, fy);
         if (!loaded[y0][x0]) load_px(x0, y0, pick_pixel());
         if (!loaded[y0][x1]) load_px(x1, y0, pick_pixel());
         if (!loaded[y1][x0]) load_px(x0, y1, pick_pixel());
         if (!loaded[y1][x1]) load_px(x1, y1, pick_pixel());
      end
      item.req_type = REQ_COMPUTE;
      item.col      = COORD_W'(c);
      item.row      = COORD_W'(r);
      item.pixel_in = PIX_W'($urandom_range(255));
      send_req(item);
   endtask

   task automatic hold_until_empty();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // loads give no result, so give the pipeline time to empty before a size write
   task automatic drain();
      settle <= 1'b1;
      hold_until_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
      settle <= 1'b0;
   endtask

   task automatic write_size(csr_addr_type addr, logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         CSR_SRC_WIDTH:  src_w = clip_size(value, MAX_WIDTH);
         CSR_SRC_HEIGHT: src_h = clip_size(value, MAX_HEIGHT);
         CSR_DST_WIDTH:  dst_w = clip_size(value, MAX_WIDTH);
         CSR_DST_HEIGHT: dst_h = clip_size(value, MAX_HEIGHT);
      endcase
      retune_steps();
   endtask

   task automatic set_sizes(logic [CSR_W-1:0] sw, logic [CSR_W-1:0] sh,
                            logic [CSR_W-1:0] dw, logic [CSR_W-1:0] dh);
      write_size(CSR_SRC_WIDTH, sw);
      write_size(CSR_SRC_HEIGHT, sh);
      write_size(CSR_DST_WIDTH, dw);
      write_size(CSR_DST_HEIGHT, dh);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) hold_until_empty();
         case ($urandom_range(19))
            0, 1, 2, 3, 4:
               load_px($urandom_range(255), $urandom_range(255), PIX_W'($urandom_range(255)));
            5, 6, 7:
               resize_at($urandom_range(255), $urandom_range(255));
            default:
               resize_at($urandom_range(dst_w - 1), $urandom_range(dst_h - 1));
         endcase
      end
   endtask

   // sizes after reset: corners of the 32x32 destination and requests outside it, then two loads
   task automatic test_reset_sizes();
      resize_at(0, 0);
      resize_at(31, 31);
      resize_at(31, 0);
      resize_at(0, 31);
      resize_at(32, 0);
      resize_at(0, 32);
      resize_at(255, 255);
      load_px(255, 255, '1);
      load_px(0, 0, '0);
   endtask

   // destination size 1 gives a zero step; zero in a size register reads as 1
   task automatic test_unit_dest();
      drain();
      set_sizes('0, CSR_W'(1), CSR_W'(1), '0);
      resize_at(0, 0);
      resize_at(1, 0);
      resize_at(0, 1);
      drain();
      set_sizes(CSR_W'(1), CSR_W'(256), CSR_W'(256), CSR_W'(1));
      resize_at(255, 0);
      resize_at(100, 0);
      resize_at(0, 1);
   endtask

   // sizes above the store clamp to it: identity mapping over the full range
   task automatic test_full_range();
      drain();
      set_sizes('1, CSR_W'(300), CSR_W'(256), '1);
      resize_at(255, 255);
      resize_at(0, 255);
      resize_at(255, 0);
      resize_at(128, 77);
   endtask

   // uniform source at both pixel extremes, fractional upscale 3x3 to 4x4
   task automatic test_flat_fill();
      drain();
      set_sizes(CSR_W'(3), CSR_W'(3), CSR_W'(4), CSR_W'(4));
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            load_px(c, r, '1);
      resize_at(1, 1);
      resize_at(2, 2);
      resize_at(3, 3);
      resize_at(3, 0);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            load_px(c, r, '0);
      resize_at(1, 2);
      resize_at(2, 1);
      resize_at(4, 3);
   endtask

   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         send_gap_pct    = (mode == 0) ? 25 : (mode == 1) ? 65 : 0;
         recv_stall_pct <= (mode == 0) ? 65 : (mode == 1) ? 25 : 0;
         for (int k = 0; k < 2; k++) begin
            drain();
            set_sizes(rand_size(), rand_size(), rand_size(), rand_size());
            run_random(110);
         end
      end
   endtask

   initial begin
      src_w = 256;
      src_h = 256;
      dst_w = 32;
      dst_h = 32;
      retune_steps();
      send_gap_pct    = 25;
      recv_stall_pct <= 65;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_unit_dest();
      test_full_range();
      test_flat_fill();
      test_random_traffic();
      drain();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
